[src/bmde_pkg.sv]
// ----------------------------------------------------------------------------
// bmde_pkg
// Shared types and constants for the 3x3 binary morphology block.
// ----------------------------------------------------------------------------
package bmde_pkg;

	localparam int unsigned MAX_ROWS_DEF = 2048;
	localparam int unsigned ROWS_W       = 12;
	localparam int unsigned COLS_W       = 16;
	localparam int unsigned MASK_W       = 9;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd3;

	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;
	localparam logic CMD_PIXEL   = 1'b0;
	localparam logic CMD_FLUSH   = 1'b1;

	// classified request from the front end to the back end
	typedef struct packed {
		logic pix;
		logic first_col;   // column_position == 0
		logic second_col;  // column_position == 1
		logic emit;
		logic top;         // output row is 0
		logic bottom;      // output row is last
		logic left;        // output column is 0
		logic right;       // output column is last
		logic last;
	} bmde_req_t;

	function automatic logic [MASK_W-1:0] reflect9(input logic [MASK_W-1:0] m);
		logic [MASK_W-1:0] r;
		for (int k = 0; k < MASK_W; k++)
			r[MASK_W-1-k] = m[k];
		return r;
	endfunction

endpackage

[src/bmde_front.sv]
// ----------------------------------------------------------------------------
// bmde_front
// Tracks frame position and classifies each request for the back end.
// ----------------------------------------------------------------------------
module bmde_front #(
	parameter int unsigned MAX_ROWS = bmde_pkg::MAX_ROWS_DEF,
	parameter int unsigned RA_W     = $clog2(MAX_ROWS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            cmd,
	input  logic                            pixel,
	input  logic [bmde_pkg::ROWS_W-1:0]     rows,
	input  logic [bmde_pkg::COLS_W-1:0]     cols,
	output logic                            req_valid,
	output logic [RA_W-1:0]                 req_addr,
	output bmde_pkg::bmde_req_t             req
);

	localparam int unsigned RP_W = RA_W + 1;

	logic [RP_W-1:0]               row_q;
	logic [bmde_pkg::COLS_W:0]     col_q;
	logic [RP_W-1:0]               nrows;
	logic [bmde_pkg::COLS_W:0]     ncols;
	logic [RP_W-1:0]               r0;
	logic [bmde_pkg::COLS_W:0]     c0, c1;
	logic [RP_W-1:0]               rn;
	logic [bmde_pkg::COLS_W:0]     cn;
	logic                          skip, have, in_img;
	logic [RP_W-1:0]               ro;
	logic [bmde_pkg::COLS_W:0]     co;

	always_comb begin
		if (rows == '0)
			nrows = RP_W'(1);
		else if (32'(rows) > MAX_ROWS)
			nrows = RP_W'(MAX_ROWS);
		else
			nrows = RP_W'(rows);
		ncols = (cols == '0) ? (bmde_pkg::COLS_W+1)'(1) : {1'b0, cols};

		r0 = row_q;
		c0 = col_q;
		if (r0 >= nrows) begin
			r0 = '0;
			c0 = c0 + 1'b1;
		end
		c1 = c0;
		if (c0 > ncols + 1'b1) begin
			r0 = '0;
			c1 = '0;
		end
		skip = (cmd == bmde_pkg::CMD_FLUSH) && r0 == '0 && c1 == '0;
		in_img = (cmd == bmde_pkg::CMD_PIXEL) && (c1 < ncols);

		if (r0 != '0) begin
			have = c1 >= 1;
			ro   = r0 - 1'b1;
			co   = c1 - 1'b1;
		end else begin
			have = c1 >= 2;
			ro   = nrows - 1'b1;
			co   = c1 - 2'd2;
		end

		rn = r0 + 1'b1;
		cn = c1;
		if (rn >= nrows) begin
			rn = '0;
			cn = c1 + 1'b1;
		end

		req.pix        = in_img & pixel;
		req.first_col  = c1 == '0;
		req.second_col = c1 == 1;
		req.emit       = have && co < ncols;
		req.top        = ro == '0;
		req.bottom     = ro + 1'b1 >= nrows;
		req.left       = co == '0;
		req.right      = co + 1'b1 >= ncols;
		req.last       = ro == nrows - 1'b1 && co == ncols - 1'b1;
		if (req.emit && req.last) begin
			rn = '0;
			cn = '0;
		end
		req_addr  = RA_W'(r0);
		req_valid = in_valid && !skip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_valid) begin
			if (skip) begin
				row_q <= r0;
				col_q <= c1;
			end else begin
				row_q <= rn;
				col_q <= cn;
			end
		end
	end

endmodule

[src/bmde_back.sv]
// ----------------------------------------------------------------------------
// bmde_back
// Column store, 3x3 window and the morphology decision.
// ----------------------------------------------------------------------------
module bmde_back #(
	parameter int unsigned MAX_ROWS = bmde_pkg::MAX_ROWS_DEF,
	parameter int unsigned RA_W     = $clog2(MAX_ROWS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	input  logic [RA_W-1:0]                   req_addr,
	input  bmde_pkg::bmde_req_t               req,
	input  logic                              mode,
	input  logic [bmde_pkg::MASK_W-1:0]       mask,
	output logic                              res_valid,
	output logic                              res_pixel,
	output logic                              res_last
);

	// stage 1: store read; stage 2: window update and decision
	logic [1:0]                    mem [MAX_ROWS];
	logic [1:0]                    rd_s1;
	logic                          v_s1;
	logic [RA_W-1:0]               addr_s1;
	bmde_pkg::bmde_req_t           req_s1;
	logic                          fwd_s1;
	logic [1:0]                    fwd_d_s1;
	logic [1:0]                    old;
	logic [2:0]                    newrow;
	logic [bmde_pkg::MASK_W-1:0]   win_q, win_n, valid_m;
	logic                          result;

	always_ff @(posedge clk) begin
		if (req_valid)
			rd_s1 <= mem[req_addr];
		if (v_s1)
			mem[addr_s1] <= {old[0], req_s1.pix};
	end

	always_ff @(posedge clk) begin
		addr_s1  <= req_addr;
		req_s1   <= req;
		fwd_s1   <= v_s1 && req_valid && addr_s1 == req_addr;
		fwd_d_s1 <= {old[0], req_s1.pix};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			win_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			v_s1      <= req_valid;
			res_valid <= v_s1 && req_s1.emit;
			if (v_s1)
				win_q <= win_n;
		end
	end

	always_ff @(posedge clk) begin
		res_pixel <= result;
		res_last  <= req_s1.last;
	end

	always_comb begin
		old = fwd_s1 ? fwd_d_s1 : rd_s1;
		// entries of columns not yet written in this frame do not matter
		if (req_s1.first_col)
			old = 2'b00;
		else if (req_s1.second_col)
			old[1] = 1'b0;
		newrow  = {req_s1.pix, old[0], old[1]};
		win_n   = {newrow, win_q[8:3]};
		valid_m = '1;
		if (req_s1.top)    valid_m &= ~9'h007;
		if (req_s1.bottom) valid_m &= ~9'h1C0;
		if (req_s1.left)   valid_m &= ~9'h049;
		if (req_s1.right)  valid_m &= ~9'h124;
		if (mode == bmde_pkg::MODE_ERODE)
			result = (mask & valid_m & ~win_n) == '0;
		else
			result = (bmde_pkg::reflect9(mask) & valid_m & win_n) != '0;
	end

endmodule

[src/bmde_fifo.sv]
// ----------------------------------------------------------------------------
// bmde_fifo
// Small result queue in front of the pop side.
// ----------------------------------------------------------------------------
module bmde_fifo (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  logic [1:0] wdata,
	input  logic       rd,
	output logic [1:0] rdata,
	output logic       empty,
	output logic [2:0] count
);

	logic [1:0] buf_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign rdata = buf_q[rp_q];
	assign empty = cnt_q == '0;
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (wr)
			buf_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= wp_q + 1'b1;
			if (rd)
				rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end

endmodule

[src/binary_morph_dilate_erode_3x3.sv]
// ----------------------------------------------------------------------------
// binary_morph_dilate_erode_3x3
// Streaming 3x3 binary dilation / erosion over column-major pixels.
// ----------------------------------------------------------------------------
// Input: push a request (cmd, pixel) while full is low; one pixel per clock.
// Pixels come column by column, rows pixels per column, cols columns.
// After the frame's pixels, push rows+1 flush requests to drain the outputs.
// Output: while empty is low, out_pixel/frame_last hold the oldest result;
// pop takes it. frame_last marks the frame's last output pixel.
// Pipeline: the store read and the decision are registered in turn;
// each output pixel lags its input by one column plus one pixel.
// Throughput: one request per clock while full is low; the column store is read as a request
// is accepted and written back on the next clock, with forwarding.
// When pop stalls, results collect in a four-entry queue; full rises once
// the queue and the two requests in flight could fill it.
// Reset clears positions, window and queue; the column store needs none.
// Configuration (mode, mask, rows, cols) is written through wr_en/wr_idx/
// wr_data; the user must do so only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module binary_morph_dilate_erode_3x3 #(
	parameter int unsigned MAX_ROWS = bmde_pkg::MAX_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic                              pixel,
	output logic                              empty,
	input  logic                              pop,
	output logic                              out_pixel,
	output logic                              frame_last,
	input  logic                              wr_en,
	input  logic [bmde_pkg::CFG_IDX_W-1:0]    wr_idx,
	input  logic [bmde_pkg::CFG_DATA_W-1:0]   wr_data
);

	localparam int unsigned RA_W = $clog2(MAX_ROWS);

	logic                            mode_q;
	logic [bmde_pkg::MASK_W-1:0]     mask_q;
	logic [bmde_pkg::ROWS_W-1:0]     rows_q;
	logic [bmde_pkg::COLS_W-1:0]     cols_q;
	logic                            req_valid, res_valid, res_pixel, res_last;
	logic [RA_W-1:0]                 req_addr;
	bmde_pkg::bmde_req_t             req;
	logic [1:0]                      rdata;
	logic [2:0]                      count;
	logic [1:0]                      infl_q;
	logic                            accept;

	// infl_q tracks accepted requests that have not reached the queue yet
	assign accept = push && !full;
	assign full   = ({1'b0, count} + {3'b0, infl_q[0]} + {3'b0, infl_q[1]}) >= 4'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bmde_pkg::MODE_DILATE;
			mask_q <= '1;
			rows_q <= bmde_pkg::ROWS_W'(2048);
			cols_q <= bmde_pkg::COLS_W'(1);
			infl_q <= '0;
		end else begin
			infl_q <= {infl_q[0], accept};
			if (wr_en) begin
				unique case (wr_idx)
					bmde_pkg::REG_MODE: mode_q <= wr_data[0];
					bmde_pkg::REG_MASK: mask_q <= wr_data[bmde_pkg::MASK_W-1:0];
					bmde_pkg::REG_ROWS: rows_q <= wr_data[bmde_pkg::ROWS_W-1:0];
					bmde_pkg::REG_COLS: cols_q <= wr_data[bmde_pkg::COLS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	bmde_front #(.MAX_ROWS(MAX_ROWS), .RA_W(RA_W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.cmd       (cmd),
		.pixel     (pixel),
		.rows      (rows_q),
		.cols      (cols_q),
		.req_valid (req_valid),
		.req_addr  (req_addr),
		.req       (req)
	);

	bmde_back #(.MAX_ROWS(MAX_ROWS), .RA_W(RA_W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_addr  (req_addr),
		.req       (req),
		.mode      (mode_q),
		.mask      (mask_q),
		.res_valid (res_valid),
		.res_pixel (res_pixel),
		.res_last  (res_last)
	);

	bmde_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_valid),
		.wdata  ({res_last, res_pixel}),
		.rd     (pop && !empty),
		.rdata  (rdata),
		.empty  (empty),
		.count  (count)
	);

	assign out_pixel  = rdata[0];
	assign frame_last = rdata[1];

endmodule

[bench/tb_binary_morph_dilate_erode_3x3.sv]
// ----------------------------------------------------------------------------
// tb_binary_morph_dilate_erode_3x3
// Self-checking bench for the streaming 3x3 binary dilation / erosion block.
// A scoreboard tracks window, column store and scan position, predicts each
// output pixel and frame_last, and checks results in order. Directed frames
// cover borders, ignored and early flushes and geometry clamping; random
// frames follow under bursty requests, a patterned pop and one long stall.
// ----------------------------------------------------------------------------
module tb_binary_morph_dilate_erode_3x3;

	class morph_scoreboard;
		typedef struct packed {
			bit pix;
			bit last;
		} morph_out_t;

		bit                        mode_r;
		bit [bmde_pkg::MASK_W-1:0] mask_r;
		bit [bmde_pkg::ROWS_W-1:0] rows_r;
		bit [bmde_pkg::COLS_W-1:0] cols_r;
		bit [1:0]                  col_store [bmde_pkg::MAX_ROWS_DEF];
		bit [8:0]                  win;
		int unsigned               row_pos;
		int unsigned               col_pos;
		morph_out_t                expected_q [$];
		int                        mismatches;

		function new();
			mode_r = bmde_pkg::MODE_DILATE;
			mask_r = '1;
			rows_r = 12'd2048;
			cols_r = 16'd1;
			win = '0;
			row_pos = 0;
			col_pos = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [bmde_pkg::CFG_IDX_W-1:0] idx,
			logic [bmde_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				bmde_pkg::REG_MODE: mode_r = d[0];
				bmde_pkg::REG_MASK: mask_r = d[bmde_pkg::MASK_W-1:0];
				bmde_pkg::REG_ROWS: rows_r = d[bmde_pkg::ROWS_W-1:0];
				bmde_pkg::REG_COLS: cols_r = d[bmde_pkg::COLS_W-1:0];
			endcase
		endfunction

		function int unsigned eff_rows();
			return rows_r == 0 ? 1 : (rows_r > bmde_pkg::MAX_ROWS_DEF ?
				bmde_pkg::MAX_ROWS_DEF : rows_r);
		endfunction

		function int unsigned eff_cols();
			return cols_r == 0 ? 1 : cols_r;
		endfunction

		function void note_request(bit c, bit p);
			int unsigned nr, nc, r, cc, ro, co;
			bit [1:0]    old;
			bit [8:0]    valid, refl;
			bit          have, px, res, last;
			nr = eff_rows();
			nc = eff_cols();
			px = (c == bmde_pkg::CMD_FLUSH) ? 1'b0 : p;
			if (row_pos >= nr) begin
				row_pos = 0;
				col_pos++;
			end
			if (col_pos > nc + 1) begin
				row_pos = 0;
				col_pos = 0;
			end
			if (c == bmde_pkg::CMD_FLUSH && row_pos == 0 && col_pos == 0)
				return;
			r = row_pos;
			cc = col_pos;
			if (cc >= nc)
				px = 1'b0;
			old = col_store[r];
			col_store[r] = {old[0], px};
			win = {px, old[0], old[1], win[8:3]};
			if (r >= 1) begin
				have = cc >= 1;
				ro = r - 1;
				co = cc - 1;
			end else begin
				have = cc >= 2;
				ro = nr - 1;
				co = cc - 2;
			end
			row_pos = r + 1;
			if (row_pos >= nr) begin
				row_pos = 0;
				col_pos = cc + 1;
			end
			if (!have)
				return;
			if (co >= nc)
				return;
			valid = '1;
			if (ro == 0) valid &= ~9'h007;
			if (ro + 1 >= nr) valid &= ~9'h1C0;
			if (co == 0) valid &= ~9'h049;
			if (co + 1 >= nc) valid &= ~9'h124;
			for (int k = 0; k < 9; k++)
				refl[8-k] = mask_r[k];
			if (mode_r == bmde_pkg::MODE_ERODE)
				res = (mask_r & valid & ~win) == 0;
			else
				res = (refl & valid & win) != 0;
			last = (ro == nr - 1) && (co == nc - 1);
			expected_q.push_back('{res, last});
			if (last) begin
				row_pos = 0;
				col_pos = 0;
			end
		endfunction

		function void check_result(bit p, bit l);
			morph_out_t e;
			if (expected_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: pixel %0b last %0b", p, l);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			if (e.pix !== p || e.last !== l) begin
				if (mismatches < 10)
					$display("mismatch: expected pixel %0b last %0b, got pixel %0b last %0b",
						e.pix, e.last, p, l);
				mismatches++;
			end
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              push;
	logic                              full;
	logic                              cmd;
	logic                              pixel;
	logic                              empty;
	logic                              pop;
	logic                              out_pixel;
	logic                              frame_last;
	logic                              wr_en;
	logic [bmde_pkg::CFG_IDX_W-1:0]    wr_idx;
	logic [bmde_pkg::CFG_DATA_W-1:0]   wr_data;

	morph_scoreboard sb = new();
	int  burst_left = 0;
	int  pixels_sent = 0;
	bit  hold_pop = 0;

	binary_morph_dilate_erode_3x3 u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.pixel      (pixel),
		.empty      (empty),
		.pop        (pop),
		.out_pixel  (out_pixel),
		.frame_last (frame_last),
		.wr_en      (wr_en),
		.wr_idx     (wr_idx),
		.wr_data    (wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// request and result monitor
	always @(posedge clk) begin
		if (arst_n && push && !full)
			sb.note_request(cmd, pixel);
		if (arst_n && pop && !empty)
			sb.check_result(out_pixel, frame_last);
	end

	// pop pattern: always ready, coin flip or one in four, the style redrawn at random
	always @(posedge clk) begin
		int unsigned cyc;
		int unsigned style;
		if (!arst_n) begin
			pop <= 1'b0;
			cyc = 0;
			style = 0;
		end else begin
			if (cyc % 64 == 0)
				style = $urandom_range(0, 2);
			cyc++;
			if (hold_pop)
				pop <= 1'b0;
			else if (style == 0)
				pop <= 1'b1;
			else if (style == 1)
				pop <= 1'($urandom_range(0, 1));
			else
				pop <= (cyc % 4 == 0);
		end
	end

	// one long stall on the result side while requests keep coming
	initial begin
		wait (pixels_sent >= 300);
		@(posedge clk);
		hold_pop <= 1'b1;
		repeat (400) @(posedge clk);
		hold_pop <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_item(input bit c, input bit p);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 24);
		end
		push <= 1'b1;
		cmd <= c;
		pixel <= p;
		do @(posedge clk); while (full);
		burst_left--;
		if (c == bmde_pkg::CMD_PIXEL)
			pixels_sent++;
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(bit m, bit [bmde_pkg::MASK_W-1:0] mk,
		bit [bmde_pkg::ROWS_W-1:0] r, bit [bmde_pkg::COLS_W-1:0] c);
		logic [bmde_pkg::CFG_DATA_W-1:0] d [4];
		logic [3:0] junk;
		junk = 4'($urandom);
		d[bmde_pkg::REG_MODE] = {junk, 11'd0, m};
		d[bmde_pkg::REG_MASK] = {junk, 3'd0, mk};
		d[bmde_pkg::REG_ROWS] = {junk, r};
		d[bmde_pkg::REG_COLS] = c;
		wait_idle();
		for (int i = 0; i < 4; i++) begin
			wr_en <= 1'b1;
			wr_idx <= bmde_pkg::CFG_IDX_W'(i);
			wr_data <= d[i];
			@(posedge clk);
			sb.write_reg(bmde_pkg::CFG_IDX_W'(i), d[i]);
		end
		wr_en <= 1'b0;
	endtask

	// one frame of pixels, its drain, and optional noise around it
	task automatic run_frame(bit noisy);
		int unsigned nr, nc, style;
		bit          p;
		nr = sb.eff_rows();
		nc = sb.eff_cols();
		style = $urandom_range(0, 3);
		if (noisy && $urandom_range(0, 3) == 0)
			send_item(bmde_pkg::CMD_FLUSH, 1'($urandom));
		for (int i = 0; i < nr * nc; i++) begin
			case (style)
				1: p = $urandom_range(0, 7) != 0;
				2: p = $urandom_range(0, 7) == 0;
				default: p = 1'($urandom);
			endcase
			// a flush at the first pixel would be ignored and leave the frame open
			if (noisy && i != 0 && $urandom_range(0, 40) == 0)
				send_item(bmde_pkg::CMD_FLUSH, p);
			else
				send_item(bmde_pkg::CMD_PIXEL, p);
		end
		for (int i = 0; i <= nr; i++) begin
			if (noisy && $urandom_range(0, 9) == 0)
				send_item(bmde_pkg::CMD_PIXEL, 1'($urandom));
			else
				send_item(bmde_pkg::CMD_FLUSH, 1'($urandom));
		end
		if (noisy && $urandom_range(0, 3) == 0)
			send_item(bmde_pkg::CMD_FLUSH, 1'($urandom));
	endtask

	initial begin
		bit [bmde_pkg::MASK_W-1:0] mk;
		arst_n = 1'b0;
		push = 1'b0;
		cmd = bmde_pkg::CMD_PIXEL;
		pixel = 1'b0;
		wr_en = 1'b0;
		wr_idx = bmde_pkg::REG_MODE;
		wr_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: erosion on a 3x3 frame with a hole, stray flushes around it
		configure(bmde_pkg::MODE_ERODE, 9'h1FF, 12'd3, 16'd3);
		send_item(bmde_pkg::CMD_FLUSH, 1'b1);
		for (int i = 0; i < 9; i++)
			send_item(bmde_pkg::CMD_PIXEL, i != 4);
		repeat (4) send_item(bmde_pkg::CMD_FLUSH, 1'b0);
		send_item(bmde_pkg::CMD_FLUSH, 1'b0);
		// directed: dilation on 2x2 with an early flush and pixels as drain
		configure(bmde_pkg::MODE_DILATE, 9'h010, 12'd2, 16'd2);
		send_item(bmde_pkg::CMD_PIXEL, 1'b1);
		send_item(bmde_pkg::CMD_FLUSH, 1'b1);
		send_item(bmde_pkg::CMD_PIXEL, 1'b0);
		send_item(bmde_pkg::CMD_PIXEL, 1'b1);
		repeat (3) send_item(bmde_pkg::CMD_PIXEL, 1'b1);
		// directed: zero geometry clamps to one pixel, empty mask
		configure(bmde_pkg::MODE_ERODE, 9'h000, 12'd0, 16'd0);
		send_item(bmde_pkg::CMD_PIXEL, 1'b0);
		repeat (2) send_item(bmde_pkg::CMD_FLUSH, 1'b0);

		while (pixels_sent < 600) begin
			case ($urandom_range(0, 3))
				0: mk = 9'h000;
				1: mk = 9'h1FF;
				default: mk = bmde_pkg::MASK_W'($urandom);
			endcase
			configure(1'($urandom), mk, 12'($urandom_range(0, 8)),
				16'($urandom_range(0, 8)));
			repeat ($urandom_range(1, 4)) run_frame(1'b1);
		end

		// widest frame, left unfinished
		configure(bmde_pkg::MODE_DILATE, bmde_pkg::MASK_W'($urandom), 12'd2, 16'hFFFF);
		repeat (100) send_item(bmde_pkg::CMD_PIXEL, 1'($urandom));

		push <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.mismatches++;
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
src/bmde_pkg.sv
src/bmde_front.sv
src/bmde_back.sv
src/bmde_fifo.sv
src/binary_morph_dilate_erode_3x3.sv
bench/tb_binary_morph_dilate_erode_3x3.sv
